### hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Ring geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths of the request and result items
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SWAP       = 3'd4
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Request item as held in the input register
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] push_word;
    logic [POS_W-1:0]  first_position;
    logic [POS_W-1:0]  second_position;
  } req_t;

  // Store access command from the control unit
  typedef struct packed {
    logic [PTR_W-1:0] rd_a_addr;
    logic [PTR_W-1:0] rd_b_addr;
    logic             wr_a_en;
    logic             wr_a_push;
    logic [PTR_W-1:0] wr_a_addr;
    logic             wr_b_en;
    logic [PTR_W-1:0] wr_b_addr;
    logic             pop_ok;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/bdq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::REQ_W-1:0]    req_type;
  logic [bdq_pkg::WORD_W-1:0]   push_word;
  logic [bdq_pkg::POS_W-1:0]    first_position;
  logic [bdq_pkg::POS_W-1:0]    second_position;

  modport source (
    output valid, req_type, push_word, first_position, second_position,
    input  ready
  );

  modport sink (
    input  valid, req_type, push_word, first_position, second_position,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/bdq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::STATUS_W-1:0]  status;
  logic [bdq_pkg::WORD_W-1:0]    pop_word;
  logic [bdq_pkg::FILL_W-1:0]    fill_count;

  modport source (
    output valid, status, pop_word, fill_count,
    input  ready
  );

  modport sink (
    input  valid, status, pop_word, fill_count,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/bounded_deque_with_swap_top.sv
// Bounded deque with swap: ring of DEPTH words, front pointer and count.
// A request is held in the input register from its accept and moves on to the
// result register when that register is free or being drained.
// Throughput: one request per cycle while results are drained, set by the
// combinational decode and register-file update between the two registers.
// Reset (rst, synchronous): deque empty, front pointer zero, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_swap_top (
  input  wire logic  clk,
  input  wire logic  rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  bdq_pkg::req_t                  req_q;
  logic                           req_valid;
  logic                           advance;
  bdq_pkg::cmd_t                  cmd;
  bdq_pkg::status_t               status_next;
  logic [bdq_pkg::CNT_W-1:0]      count_next;
  logic [bdq_pkg::CNT_W-1:0]      count;
  logic [bdq_pkg::WORD_W-1:0]     rd_a_data;
  logic                           rsp_valid;
  logic [bdq_pkg::STATUS_W-1:0]   rsp_status;
  logic [bdq_pkg::WORD_W-1:0]     rsp_pop_word;
  logic [bdq_pkg::FILL_W-1:0]     rsp_fill_count;

  // Move an item forward when the result register is free or being drained
  assign advance   = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_q.req_type        <= req.req_type;
      req_q.push_word       <= req.push_word;
      req_q.first_position  <= req.first_position;
      req_q.second_position <= req.second_position;
    end
  end

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .req        (req_q),
    .cmd        (cmd),
    .status     (status_next),
    .count_next (count_next),
    .count      (count)
  );

  bdq_store u_store (
    .clk       (clk),
    .advance   (advance),
    .cmd       (cmd),
    .push_word (req_q.push_word),
    .rd_a_data (rd_a_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_status     <= status_next;
      rsp_pop_word   <= cmd.pop_ok ? rd_a_data : '0;
      rsp_fill_count <= bdq_pkg::FILL_W'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.pop_word   = rsp_pop_word;
  assign rsp.fill_count = rsp_fill_count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(count))
    else $error("entry count moved without an item");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid)
    else $error("processed item produced no result");

  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == bdq_pkg::ST_FULL) |->
      rsp.fill_count == bdq_pkg::FILL_W'(bdq_pkg::DEPTH))
    else $error("full status with deque not full");

endmodule

`default_nettype wire

### hw/rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire bdq_pkg::req_t               req,
  output bdq_pkg::cmd_t                    cmd,
  output bdq_pkg::status_t                 status,
  output logic [bdq_pkg::CNT_W-1:0]        count_next,
  output logic [bdq_pkg::CNT_W-1:0]        count
);

  logic [bdq_pkg::PTR_W-1:0] front;
  logic [bdq_pkg::PTR_W-1:0] front_next;
  logic [bdq_pkg::PTR_W-1:0] front_dec;
  logic [bdq_pkg::PTR_W-1:0] tail_slot;
  logic [bdq_pkg::PTR_W-1:0] back_slot;
  logic [bdq_pkg::PTR_W-1:0] slot_a;
  logic [bdq_pkg::PTR_W-1:0] slot_b;
  logic                      full;
  logic                      empty;
  logic                      out_of_range;

  // Ring slots relative to the front
  assign full      = (count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign front_dec = front - bdq_pkg::PTR_W'(1);
  assign tail_slot = front + bdq_pkg::PTR_W'(count);
  assign back_slot = tail_slot - bdq_pkg::PTR_W'(1);
  assign slot_a    = front + bdq_pkg::PTR_W'(req.first_position);
  assign slot_b    = front + bdq_pkg::PTR_W'(req.second_position);
  assign out_of_range = (bdq_pkg::CNT_W'(req.first_position) >= count) ||
                        (bdq_pkg::CNT_W'(req.second_position) >= count);

  // Decode the request against the current ring state
  always_comb begin
    front_next    = front;
    count_next    = count;
    status        = bdq_pkg::ST_OK;
    cmd           = '0;
    cmd.rd_a_addr = slot_a;
    cmd.rd_b_addr = slot_b;
    unique case (req.req_type)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          front_next    = front_dec;
          count_next    = count + bdq_pkg::CNT_W'(1);
          cmd.wr_a_en   = 1'b1;
          cmd.wr_a_push = 1'b1;
          cmd.wr_a_addr = front_dec;
        end
      end
      bdq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          count_next    = count + bdq_pkg::CNT_W'(1);
          cmd.wr_a_en   = 1'b1;
          cmd.wr_a_push = 1'b1;
          cmd.wr_a_addr = tail_slot;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        cmd.rd_a_addr = front;
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          front_next = front + bdq_pkg::PTR_W'(1);
          count_next = count - bdq_pkg::CNT_W'(1);
          cmd.pop_ok = 1'b1;
        end
      end
      bdq_pkg::REQ_POP_BACK: begin
        cmd.rd_a_addr = back_slot;
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          count_next = count - bdq_pkg::CNT_W'(1);
          cmd.pop_ok = 1'b1;
        end
      end
      bdq_pkg::REQ_SWAP: begin
        if (out_of_range) begin
          status = bdq_pkg::ST_RANGE;
        end else begin
          // cross the two read ports back into the two slots
          cmd.wr_a_en   = 1'b1;
          cmd.wr_a_addr = slot_a;
          cmd.wr_b_en   = 1'b1;
          cmd.wr_b_addr = slot_b;
        end
      end
      default: begin
        // unused codes leave the deque alone
      end
    endcase
  end

  // Advance the pointer and count when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (advance) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bdq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_store (
  input  wire logic                         clk,
  input  wire logic                         advance,
  input  wire bdq_pkg::cmd_t                cmd,
  input  wire logic [bdq_pkg::WORD_W-1:0]   push_word,
  output logic [bdq_pkg::WORD_W-1:0]        rd_a_data
);

  logic [bdq_pkg::WORD_W-1:0] entries [bdq_pkg::DEPTH];
  logic [bdq_pkg::WORD_W-1:0] rd_b_data;
  logic [bdq_pkg::WORD_W-1:0] wr_a_data;

  // Two read ports: pop or first swap slot, and second swap slot
  assign rd_a_data = entries[cmd.rd_a_addr];
  assign rd_b_data = entries[cmd.rd_b_addr];
  assign wr_a_data = cmd.wr_a_push ? push_word : rd_b_data;

  // Write the pushed word, or both halves of a swap
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd.wr_a_en) begin
        entries[cmd.wr_a_addr] <= wr_a_data;
      end
      if (cmd.wr_b_en) begin
        entries[cmd.wr_b_addr] <= rd_a_data;
      end
    end
  end

endmodule

`default_nettype wire
